FILE: rtl/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// shared widths, register map and sequencer states of the moving average filter
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int SAMPLE_W  = 16;  // sample and average width
  localparam int WIN_W     = 7;   // window length register width
  localparam int SUM_W     = 23;  // signed sum of up to 127 samples
  localparam int DIV_CNT_W = 5;   // counts the SUM_W divide steps
  localparam int PADDR_W   = 3;   // register word index in paddr[2]
  localparam int PDATA_W   = 32;

  // register word index
  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [2:0] {
    S_CLEAR,   // zero the sample store after reset
    S_IDLE,    // wait for a request or a register write
    S_SUM,     // re-sum the window after a length change
    S_SUMEND,  // add the last entry of the sweep
    S_UPDATE,  // write the sample, update the running sum
    S_PREP,    // load the divider
    S_DIV,     // one quotient bit per cycle
    S_DONE     // hand the quotient to the output register
  } state_t;

endpackage

FILE: rtl/moving_average_filter_top.sv
// ----------------------------------------------------------------------------
// moving_average_filter_top
// boxcar moving average with a circular sample store and a serial divider
// ----------------------------------------------------------------------------
// usage
//   sample channel: a request (sample_valid high, sample_stall low) carries one
//   signed sample. it is written into the circular store at the write position,
//   which then advances and wraps at the window length.
//   average channel: one result per request, the sum of the first window_length
//   store entries divided by window_length, truncated toward zero.
//   window_length register at byte address 0 (1..MAX_WINDOW, 0 reads back as 1,
//   larger values saturate). a write restarts the write position at 0, keeps the
//   stored samples and re-sums the window while sample_stall stays high.
// request sequence
//   an accepted request runs one running sum update (the store read overlaps
//   acceptance), one divider load, 23 restoring divide steps in the shared
//   subtract and compare unit and one output load. the next request is taken
//   only once the result is loaded and the block is back in idle.
// reset
//   rst clears control state, then a clearing pass over all MAX_WINDOW entries
//   zeroes the store; sample_stall stays high meanwhile.
// stalls
//   the result sits in an output register; while average_stall is high the
//   block may still take the next request and holds its own result until free.
// ----------------------------------------------------------------------------
module moving_average_filter_top #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample channel
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [mavg_pkg::SAMPLE_W-1:0]  sample,
  // average channel
  output logic                                  average_valid,
  input  logic                                  average_stall,
  output logic signed [mavg_pkg::SAMPLE_W-1:0]  average,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mavg_pkg::PADDR_W-1:0]          paddr,
  input  logic [mavg_pkg::PDATA_W-1:0]          pwdata,
  output logic [mavg_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);

  import mavg_pkg::*;

  // store address width and a compare width that holds both address and length
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = (AW > WIN_W) ? AW : WIN_W;
  localparam logic [WIN_W-1:0] WIN_RST =
    (MAX_WINDOW < 64) ? WIN_W'(MAX_WINDOW) : WIN_W'(64);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);

  state_t state, state_next;

  // sample store
  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] rd_data;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [SAMPLE_W-1:0] mem_wdata;

  // control and datapath registers
  logic [WIN_W-1:0]        window;
  logic [AW-1:0]           pos;
  logic [AW-1:0]           cnt;
  logic signed [SUM_W-1:0] sum;
  logic [SAMPLE_W-1:0]     sample_reg;
  logic [SUM_W-1:0]        quo;
  logic [WIN_W-1:0]        rem;
  logic                    neg;
  logic [DIV_CNT_W-1:0]    dcnt;

  logic                    cfg_wr;
  logic                    accept;
  logic                    out_free;
  logic [WIN_W-1:0]        win_wr;
  logic [CW-1:0]           pos_inc;
  logic [CW-1:0]           win_ext;
  logic                    cnt_last;
  logic                    div_last;
  logic [WIN_W:0]          shifted;
  logic                    ge;
  logic [WIN_W:0]          diff;
  logic [SUM_W-1:0]        rd_ext;
  logic [SUM_W-1:0]        smp_ext;
  logic [SUM_W-1:0]        sum_mag;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW);
  assign prdata = (paddr[2] == REG_WINDOW) ? PDATA_W'(window) : '0;

  // saturate the written length to 1..MAX_WINDOW
  always_comb begin
    win_wr = pwdata[WIN_W-1:0];
    if (win_wr == '0) begin
      win_wr = WIN_W'(1);
    end else if (32'(win_wr) > 32'(MAX_WINDOW)) begin
      win_wr = WIN_W'(MAX_WINDOW);
    end
  end

  assign accept   = (state == S_IDLE) && sample_valid && !sample_stall;
  assign out_free = !average_valid || !average_stall;
  assign win_ext  = CW'(window);
  assign pos_inc  = CW'(pos) + CW'(1);
  assign cnt_last = (CW'(cnt) == (win_ext - CW'(1)));
  assign div_last = (dcnt == DIV_CNT_W'(SUM_W - 1));

  // shared subtract and compare unit of the restoring divider
  assign shifted = {rem, quo[SUM_W-1]};
  assign diff    = shifted - {1'b0, window};
  assign ge      = (shifted >= {1'b0, window});

  assign rd_ext  = {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
  assign smp_ext = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
  assign sum_mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (cnt == LAST_ADDR) state_next = S_IDLE;
      S_IDLE: begin
        if (cfg_wr) begin
          state_next = S_SUM;
        end else if (accept) begin
          state_next = S_UPDATE;
        end
      end
      S_SUM:    if (cnt_last) state_next = S_SUMEND;
      S_SUMEND: state_next = S_IDLE;
      S_UPDATE: state_next = S_PREP;
      S_PREP:   state_next = S_DIV;
      S_DIV:    if (div_last) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sample_stall = 1'b1;
    mem_we       = 1'b0;
    mem_addr     = pos;
    mem_wdata    = sample_reg;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = cnt;
        mem_wdata = '0;
      end
      // a register write in the same cycle takes the idle slot
      S_IDLE:   sample_stall = cfg_wr;
      S_SUM:    mem_addr = cnt;
      S_UPDATE: mem_we = 1'b1;
      default:  mem_addr = pos;
    endcase
  end

  // sample store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      window        <= WIN_RST;
      pos           <= '0;
      cnt           <= '0;
      sum           <= '0;
      dcnt          <= '0;
      average_valid <= 1'b0;
    end else begin
      state <= state_next;

      if ((state == S_DONE) && out_free) begin
        average_valid <= 1'b1;
      end else if (!average_stall) begin
        average_valid <= 1'b0;
      end

      if (cfg_wr) begin
        window <= win_wr;
        pos    <= '0;
      end

      case (state)
        S_CLEAR: begin
          cnt <= (cnt == LAST_ADDR) ? '0 : cnt + AW'(1);
        end
        S_IDLE: begin
          if (cfg_wr) begin
            cnt <= '0;
            sum <= '0;
          end else if (accept) begin
            sample_reg <= sample;
          end
        end
        S_SUM: begin
          // read data is registered and arrives in the cycle after its address
          if (cnt != '0) begin
            sum <= sum + $signed(rd_ext);
          end
          if (!cnt_last) begin
            cnt <= cnt + AW'(1);
          end
        end
        S_SUMEND: begin
          sum <= sum + $signed(rd_ext);
          cnt <= '0;
        end
        S_UPDATE: begin
          // drop the overwritten entry, add the new one
          sum <= sum - $signed(rd_ext) + $signed(smp_ext);
          pos <= (pos_inc == win_ext) ? '0 : pos_inc[AW-1:0];
        end
        S_PREP: begin
          quo  <= sum_mag;
          neg  <= sum[SUM_W-1];
          rem  <= '0;
          dcnt <= '0;
        end
        S_DIV: begin
          rem  <= ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
          quo  <= {quo[SUM_W-2:0], ge};
          dcnt <= dcnt + DIV_CNT_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            average <= neg ? (~quo[SAMPLE_W-1:0] + SAMPLE_W'(1))
                           : quo[SAMPLE_W-1:0];
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // write position stays inside the window
  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    CW'(pos) < win_ext)
    else $error("write position outside the window");

  // window length stays within 1..MAX_WINDOW
  a_window_range: assert property (@(posedge clk) disable iff (rst)
    (window != '0) && (32'(window) <= 32'(MAX_WINDOW)))
    else $error("window length out of range");

  // a finished quotient reaches a free output register at once
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && !average_valid |=> average_valid)
    else $error("result not loaded into a free output register");

  // an accepted request goes straight to the store update
  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_wr |=> (state == S_UPDATE))
    else $error("accepted request did not start the update");
`endif

endmodule

FILE: sim/moving_average_filter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moving_average_filter_top_tb
// self-checking bench for the boxcar moving average filter
// ----------------------------------------------------------------------------
// Samples go in on the request channel and averages come back on the result
// channel. Both channels idle at random. A scoreboard keeps its own copy of
// the sample store, the write position and the window length. For every
// accepted request it computes the expected average, and it compares each
// accepted result in order. The window register is read once after reset,
// then written and read back through the register port while the block is
// idle, in a series of phases that includes the saturating values, an ignored
// write to an unused address and stale store contents.
// ----------------------------------------------------------------------------
module moving_average_filter_top_tb;

  import mavg_pkg::*;

  localparam int MAX_WINDOW   = 64;
  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_ITEMS  = 70;    // tail of the run with no idling
  localparam int DRAIN_CYCLES = 40;    // outlasts a whole request

  // register addresses: the word index sits in paddr[2]
  localparam logic REG_SPARE = 1'b1;   // decoded by nothing, writes are dropped
  localparam logic [PADDR_W-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE  = {REG_SPARE, 2'b00};

  // shapes of random sample streams
  typedef enum int {MIX_FULL, MIX_HIGH, MIX_LOW, MIX_SMALL} mix_t;

  // --------------------------------------------------------------------------
  // scoreboard: running copy of the filter plus the queue of pending averages
  // --------------------------------------------------------------------------
  class mavg_scoreboard;
    logic signed [SAMPLE_W-1:0] sample_store [MAX_WINDOW];
    int unsigned write_pos;
    int unsigned window;
    logic signed [SAMPLE_W-1:0] pending_averages [$];
    int unsigned mismatches;

    function new();
      foreach (sample_store[i]) sample_store[i] = '0;
      write_pos  = 0;
      window     = MAX_WINDOW;
      mismatches = 0;
    endfunction

    function void report(string msg);
      if (mismatches < 10) $display("%s", msg);
      mismatches++;
    endfunction

    // only the low register bits count, then saturate to 1..MAX_WINDOW
    function void set_window(logic [PDATA_W-1:0] data);
      int unsigned len;
      len = 32'(data[WIN_W-1:0]);
      if (len < 1) len = 1;
      if (len > MAX_WINDOW) len = MAX_WINDOW;
      window    = len;
      write_pos = 0;
    endfunction

    function void check_window(logic [PDATA_W-1:0] got);
      if (got !== PDATA_W'(window))
        report($sformatf("window readback mismatch: expected %0d, got %0d", window, got));
    endfunction

    // store the sample, advance the position, average the window
    function void take_sample(logic signed [SAMPLE_W-1:0] value);
      int sum;
      if (write_pos >= window) write_pos = 0;
      sample_store[write_pos] = value;
      write_pos++;
      if (write_pos >= window) write_pos = 0;
      sum = 0;
      for (int i = 0; i < window; i++) sum += int'(sample_store[i]);
      // int division truncates toward zero
      pending_averages.push_back(SAMPLE_W'(sum / int'(window)));
    endfunction

    function void check_average(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (pending_averages.size() == 0) begin
        report($sformatf("average %0d with no request pending", got));
        return;
      end
      want = pending_averages.pop_front();
      if (got !== want)
        report($sformatf("average mismatch: expected %0d, got %0d", want, got));
    endfunction

    function int unsigned outstanding();
      return pending_averages.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic clk;
  logic rst = 1'b1;

  logic                        sample_valid = 1'b0;
  logic                        sample_stall;
  logic signed [SAMPLE_W-1:0]  sample = '0;
  logic                        average_valid;
  logic                        average_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]  average;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [PADDR_W-1:0]          paddr = '0;
  logic [PDATA_W-1:0]          pwdata = '0;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;

  mavg_scoreboard scoreboard;

  // idling rates in percent, changed per phase
  int unsigned send_gap_pct  = 0;
  int unsigned drain_gap_pct = 0;
  int unsigned stall_hold    = 0;

  moving_average_filter_top #(
    .MAX_WINDOW(MAX_WINDOW)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample        (sample),
    .average_valid (average_valid),
    .average_stall (average_stall),
    .average       (average),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure: random bursts of stalls
  always @(negedge clk) begin
    if (stall_hold != 0) begin
      stall_hold    <= stall_hold - 1;
      average_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < drain_gap_pct) begin
      stall_hold    <= $urandom_range(0, 3);
      average_stall <= 1'b1;
    end else begin
      average_stall <= 1'b0;
    end
  end

  // every accepted result is checked against the oldest pending average
  always @(posedge clk) begin
    if (!rst && average_valid && !average_stall) scoreboard.check_average(average);
  end

  // --------------------------------------------------------------------------
  // drivers: all entered and left at a falling edge
  // --------------------------------------------------------------------------

  // one request, optionally after an idle burst with junk on the payload
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      sample_valid <= 1'b0;
      sample       <= SAMPLE_W'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    scoreboard.take_sample(value);
    @(negedge clk);
  endtask

  // drop the request line and wait until the block has nothing in flight
  task automatic drain();
    sample_valid <= 1'b0;
    while (scoreboard.outstanding() != 0) @(negedge clk);
    while (sample_stall) @(negedge clk);
  endtask

  // register write: setup, access, then wait out the window re-sum
  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_WINDOW) scoreboard.set_window(data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    while (sample_stall) @(negedge clk);
  endtask

  // read the window register back and compare
  task automatic reg_read_window();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WINDOW;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    scoreboard.check_window(prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // random sample drawn from the stream shape of the phase, extremes now and then
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(mix_t mix);
    if ($urandom_range(0, 15) == 0)
      return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    case (mix)
      MIX_HIGH:  return 16'sh7FFF - SAMPLE_W'($urandom_range(0, 255));
      MIX_LOW:   return 16'sh8000 + SAMPLE_W'($urandom_range(0, 255));
      MIX_SMALL: return SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
      default:   return SAMPLE_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned    random_sent;
    int unsigned    phase_len;
    int unsigned    choice;
    int unsigned    win_val;
    logic [PDATA_W-1:0] data;
    mix_t           mix;

    scoreboard = new();
    random_sent = 0;

    // hold reset, then the block clears its store on its own
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (sample_stall !== 1'b0) @(negedge clk);

    send_gap_pct  = 30;
    drain_gap_pct = 30;

    // full window after reset, samples mostly land against a zeroed store
    reg_read_window();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    drain();

    // zero window saturates to one: average equals the sample
    reg_write(ADDR_WINDOW, 32'd0);
    reg_read_window();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    drain();

    // write to the unused address mid-window must keep the write position
    reg_write(ADDR_WINDOW, 32'd3);
    send_sample(16'sd100);
    send_sample(-16'sd200);
    drain();
    reg_write(ADDR_SPARE, 32'hFFFF_FFFF);
    reg_read_window();
    send_sample(16'sd300);
    send_sample(-16'sd5);
    drain();

    // two-entry window: both extremes, then a sum of -1 that truncates to zero
    reg_write(ADDR_WINDOW, 32'd2);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain();

    // oversize values saturate; old samples stay in the wider window
    reg_write(ADDR_WINDOW, 32'd127);
    reg_read_window();
    send_sample(-16'sd7);
    send_sample(16'sd7);
    drain();
    reg_write(ADDR_WINDOW, 32'hFFFF_FF41);
    reg_read_window();
    send_sample(16'sd12345);

    // random phases, each with its own window, stream shape and idling
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      choice = $urandom_range(0, 11);
      case (choice)
        0:       win_val = 0;
        1:       win_val = 127;
        2:       win_val = 1;
        3:       win_val = MAX_WINDOW;
        4:       win_val = 2;
        5:       win_val = $urandom_range(MAX_WINDOW + 1, 127);
        default: win_val = $urandom_range(1, MAX_WINDOW);
      endcase
      if (choice == 6) begin
        // keep the window and position, carry on where the last phase stopped
      end else if (choice == 7) begin
        reg_write(ADDR_SPARE, $urandom);
      end else begin
        data = PDATA_W'(win_val);
        if ($urandom_range(0, 3) == 0) data |= $urandom & ~32'h7F;
        reg_write(ADDR_WINDOW, data);
        reg_read_window();
      end

      // the tail of the run goes without idling on either side
      if (random_sent + QUIET_ITEMS >= RANDOM_ITEMS) begin
        send_gap_pct  = 0;
        drain_gap_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       send_gap_pct = 0;
          1:       send_gap_pct = 25;
          default: send_gap_pct = 60;
        endcase
        case ($urandom_range(0, 2))
          0:       drain_gap_pct = 0;
          1:       drain_gap_pct = 25;
          default: drain_gap_pct = 60;
        endcase
      end

      mix = mix_t'($urandom_range(0, 3));
      phase_len = $urandom_range(4, 40);
      for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
        send_sample(pick_sample(mix));
        random_sent++;
      end
    end

    // let the last results come back, then allow for stray ones
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0)
      $display("moving_average_filter_top test passed");
    else
      $display("moving_average_filter_top test failed");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("moving_average_filter_top test failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mavg_pkg.sv
rtl/moving_average_filter_top.sv
sim/moving_average_filter_top_tb.sv
